[design/fpbp_pkg.sv]
// fpbp_pkg: shared types and constants of the framed packet byte parser
// used by fpbp_ctrl, fpbp_datapath and framed_packet_byte_parser

package fpbp_pkg;

  localparam int unsigned MAX_PAYLOAD = 64;
  localparam int unsigned LEN_W       = 7;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [7:0]       SYNC_RESET  = 8'd2;
  localparam logic [7:0]       ID_RESET    = 8'd1;
  localparam logic [7:0]       TAIL_RESET  = 8'd3;
  localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(MAX_PAYLOAD);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC  = 2'd0,
    CFG_ID    = 2'd1,
    CFG_TAIL  = 2'd2,
    CFG_LIMIT = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_SYNC,
    ST_ID,
    ST_CMD,
    ST_SUB,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_DATA,
    ST_CHECK,
    ST_TAIL,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_e;

  typedef struct packed {
    logic cap_id;
    logic cap_cmd;
    logic cap_sub;
    logic cap_len_lo;
    logic cap_len_hi;
    logic cap_check;
    logic store;
    logic cnt_inc;
    logic cnt_clr;
    logic rd_issue;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_sync;
    logic is_id;
    logic is_tail;
    logic len_zero_in;
    logic over_limit;
    logic count_done;
    logic held_zero;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

[design/fpbp_ctrl.sv]
// fpbp_ctrl: frame parsing and result emission state machine
// depends on fpbp_pkg; drives commands into fpbp_datapath

module fpbp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  fpbp_pkg::status_t sts_i,
  output fpbp_pkg::cmd_t    cmd_o
);

  fpbp_pkg::state_e state_q, state_d;
  logic             acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpbp_pkg::ST_SYNC;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q == fpbp_pkg::ST_EMIT_RD) || (state_q == fpbp_pkg::ST_EMIT_WR);
    acc        = in_valid_i && !in_stall_o;
    case (state_q)
      fpbp_pkg::ST_SYNC: begin
        if (acc && sts_i.is_sync) state_d = fpbp_pkg::ST_ID;
      end
      fpbp_pkg::ST_ID: begin
        if (acc) begin
          cmd_o.cap_id = 1'b1;
          state_d = sts_i.is_id ? fpbp_pkg::ST_CMD : fpbp_pkg::ST_SYNC;
        end
      end
      fpbp_pkg::ST_CMD: begin
        if (acc) begin
          cmd_o.cap_cmd = 1'b1;
          state_d = fpbp_pkg::ST_SUB;
        end
      end
      fpbp_pkg::ST_SUB: begin
        if (acc) begin
          cmd_o.cap_sub = 1'b1;
          state_d = fpbp_pkg::ST_LEN_LO;
        end
      end
      fpbp_pkg::ST_LEN_LO: begin
        if (acc) begin
          cmd_o.cap_len_lo = 1'b1;
          state_d = fpbp_pkg::ST_LEN_HI;
        end
      end
      fpbp_pkg::ST_LEN_HI: begin
        if (acc) begin
          cmd_o.cap_len_hi = 1'b1;
          cmd_o.cnt_clr    = 1'b1;
          state_d = sts_i.len_zero_in ? fpbp_pkg::ST_CHECK : fpbp_pkg::ST_DATA;
        end
      end
      fpbp_pkg::ST_DATA: begin
        if (acc) begin
          if (sts_i.over_limit) begin
            cmd_o.cnt_clr = 1'b1;
            state_d = fpbp_pkg::ST_SYNC;
          end else begin
            cmd_o.store = 1'b1;
            if (sts_i.count_done) begin
              cmd_o.cnt_clr = 1'b1;
              state_d = fpbp_pkg::ST_CHECK;
            end else begin
              cmd_o.cnt_inc = 1'b1;
            end
          end
        end
      end
      fpbp_pkg::ST_CHECK: begin
        if (acc) begin
          cmd_o.cap_check = 1'b1;
          state_d = fpbp_pkg::ST_TAIL;
        end
      end
      fpbp_pkg::ST_TAIL: begin
        if (acc) begin
          cmd_o.cnt_clr = 1'b1;
          state_d = sts_i.is_tail ? fpbp_pkg::ST_EMIT_RD : fpbp_pkg::ST_SYNC;
        end
      end
      fpbp_pkg::ST_EMIT_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d = fpbp_pkg::ST_EMIT_WR;
      end
      fpbp_pkg::ST_EMIT_WR: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.held_zero || sts_i.emit_last) begin
            cmd_o.cnt_clr = 1'b1;
            state_d = fpbp_pkg::ST_SYNC;
          end else begin
            cmd_o.cnt_inc = 1'b1;
            state_d = fpbp_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = fpbp_pkg::ST_SYNC;
      end
    endcase
  end

endmodule

[design/fpbp_datapath.sv]
// fpbp_datapath: configuration registers, header registers, payload store
// and result register; depends on fpbp_pkg, commanded by fpbp_ctrl

module fpbp_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fpbp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [7:0]                          cfg_data_i,
  input  logic [7:0]                          rx_byte_i,
  input  fpbp_pkg::cmd_t                      cmd_i,
  output fpbp_pkg::status_t                   sts_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [7:0]                          frame_id_o,
  output logic [7:0]                          command_o,
  output logic [7:0]                          sub_command_o,
  output logic [fpbp_pkg::LEN_W-1:0]          payload_length_o,
  output logic [7:0]                          check_byte_o,
  output logic                                has_payload_o,
  output logic [fpbp_pkg::IDX_W-1:0]          byte_index_o,
  output logic [7:0]                          payload_byte_o,
  output logic                                last_o
);

  localparam logic [fpbp_pkg::LEN_W-1:0] MaxLen = fpbp_pkg::LEN_W'(fpbp_pkg::MAX_PAYLOAD);

  logic [7:0]                 sync_q, id_val_q, tail_q;
  logic [fpbp_pkg::LEN_W-1:0] limit_q;

  logic [7:0]                 id_q, cmd_q, sub_q, lo_q, check_q;
  logic [fpbp_pkg::LEN_W-1:0] len_q;
  logic                       big_q;
  logic [fpbp_pkg::LEN_W-1:0] count_q, count_d;
  logic [7:0]                 rd_data_q;
  logic [7:0]                 mem_q [fpbp_pkg::MAX_PAYLOAD];

  logic                       out_valid_q, out_valid_d;
  logic [fpbp_pkg::LEN_W-1:0] limit_eff;
  logic [fpbp_pkg::LEN_W-1:0] count_inc;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q   <= fpbp_pkg::SYNC_RESET;
      id_val_q <= fpbp_pkg::ID_RESET;
      tail_q   <= fpbp_pkg::TAIL_RESET;
      limit_q  <= fpbp_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (fpbp_pkg::cfg_idx_e'(cfg_index_i))
        fpbp_pkg::CFG_SYNC:  sync_q   <= cfg_data_i;
        fpbp_pkg::CFG_ID:    id_val_q <= cfg_data_i;
        fpbp_pkg::CFG_TAIL:  tail_q   <= cfg_data_i;
        fpbp_pkg::CFG_LIMIT: limit_q  <= cfg_data_i[fpbp_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // header registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_id)     id_q    <= rx_byte_i;
    if (cmd_i.cap_cmd)    cmd_q   <= rx_byte_i;
    if (cmd_i.cap_sub)    sub_q   <= rx_byte_i;
    if (cmd_i.cap_len_lo) lo_q    <= rx_byte_i;
    if (cmd_i.cap_check)  check_q <= rx_byte_i;
    if (cmd_i.cap_len_hi) begin
      len_q <= lo_q[fpbp_pkg::LEN_W-1:0];
      big_q <= (rx_byte_i != 8'd0) || lo_q[7];
    end
  end

  // byte counter, shared by payload capture and emission
  assign count_inc = count_q + fpbp_pkg::LEN_W'(1);

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_clr) begin
      count_d = '0;
    end else if (cmd_i.cnt_inc) begin
      count_d = count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // payload store
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) mem_q[count_q[fpbp_pkg::IDX_W-1:0]] <= rx_byte_i;
    if (cmd_i.rd_issue) rd_data_q <= mem_q[count_q[fpbp_pkg::IDX_W-1:0]];
  end

  // status
  assign limit_eff = (limit_q > MaxLen) ? MaxLen : limit_q;

  always_comb begin
    sts_o.is_sync     = (rx_byte_i == sync_q);
    sts_o.is_id       = (rx_byte_i == id_val_q);
    sts_o.is_tail     = (rx_byte_i == tail_q);
    sts_o.len_zero_in = (lo_q == 8'd0) && (rx_byte_i == 8'd0);
    sts_o.over_limit  = big_q || (len_q > limit_eff);
    sts_o.count_done  = ({1'b0, count_q} + 8'd1) >= {1'b0, len_q};
    sts_o.held_zero   = (len_q == '0) && !big_q;
    sts_o.emit_last   = (count_inc == len_q);
    sts_o.out_free    = !out_valid_q || !out_stall_i;
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      frame_id_o       <= id_q;
      command_o        <= cmd_q;
      sub_command_o    <= sub_q;
      payload_length_o <= len_q;
      check_byte_o     <= check_q;
      has_payload_o    <= !sts_o.held_zero;
      byte_index_o     <= sts_o.held_zero ? '0 : count_q[fpbp_pkg::IDX_W-1:0];
      payload_byte_o   <= sts_o.held_zero ? 8'd0 : rd_data_q;
      last_o           <= sts_o.held_zero || sts_o.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[design/framed_packet_byte_parser.sv]
// framed_packet_byte_parser: top level of the framed packet byte parser
// depends on fpbp_pkg, fpbp_ctrl and fpbp_datapath
//
// Usage: received bytes enter on the input channel (in_valid_i, in_stall_o,
// rx_byte_i), one word per byte. Frames are sync, id, command, sub-command,
// little-endian 16-bit length, payload, checksum byte, tail. Results leave on
// the output channel (out_valid_o, out_stall_i and the field ports), one word
// per stored payload byte, or one word with has_payload_o low for an empty
// frame; last_o marks the final word of a frame.
// Throughput: one byte per cycle while a frame is parsed. After a good tail
// the input is stalled while the results are emitted; each result comes from
// the registered read of the payload store followed by the load of the
// result register. After the tail byte is taken, ST_EMIT_RD reads the store
// and ST_EMIT_WR loads the first result. Once the last result of a frame is
// loaded the parser takes bytes again while that result waits.
// When the receiver stalls, the result held in the output register stays and
// emission pauses. Reset returns the parser to hunting for sync, empties the
// output register and restores the configuration registers; the payload store
// needs no clearing. Configuration: cfg_we_i writes cfg_data_i to register
// cfg_index_i (sync, id, tail, length limit); the user must write only while
// no frame is being emitted, which the block itself does not enforce.

module framed_packet_byte_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fpbp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     frame_id_o,
  output logic [7:0]                     command_o,
  output logic [7:0]                     sub_command_o,
  output logic [fpbp_pkg::LEN_W-1:0]     payload_length_o,
  output logic [7:0]                     check_byte_o,
  output logic                           has_payload_o,
  output logic [fpbp_pkg::IDX_W-1:0]     byte_index_o,
  output logic [7:0]                     payload_byte_o,
  output logic                           last_o
);

  fpbp_pkg::cmd_t    cmd;
  fpbp_pkg::status_t sts;

  fpbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fpbp_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .rx_byte_i        (rx_byte_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .frame_id_o       (frame_id_o),
    .command_o        (command_o),
    .sub_command_o    (sub_command_o),
    .payload_length_o (payload_length_o),
    .check_byte_o     (check_byte_o),
    .has_payload_o    (has_payload_o),
    .byte_index_o     (byte_index_o),
    .payload_byte_o   (payload_byte_o),
    .last_o           (last_o)
  );

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_payload_o |-> last_o)
    else $error("empty frame word not marked last");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_payload_o |-> ({1'b0, byte_index_o} < payload_length_o))
    else $error("byte index beyond payload length");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_payload_o && last_o |->
      (({1'b0, byte_index_o} + 7'd1) == payload_length_o))
    else $error("last word not at final payload byte");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(out_valid_o && out_stall_i))
    else $error("result register overwritten while stalled");

  a_no_input_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_issue |-> in_stall_o)
    else $error("input taken during emission");

endmodule
